// ===== src/ramr_pkg.sv =====
// Shared types, widths and codes for the rational add/multiply/reduce block.
package ramr_pkg;

  // Fraction field width and derived internal widths
  localparam int FRAC_W    = 16;
  localparam int MAG_W     = 2 * FRAC_W;
  localparam int NUM_W     = 33;
  localparam int DEN_W     = 32;
  localparam int MUL_LANES = 3;
  localparam int DIV_LANES = 2;
  localparam int MUL_CW    = $clog2(FRAC_W);
  localparam int DIV_CW    = $clog2(MAG_W);
  localparam int GCD_KW    = $clog2(MAG_W);

  // Action codes
  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_MUL = 2'd1;
  localparam logic [1:0] ACT_CMP = 2'd2;

  typedef struct packed {
    logic [1:0]               action;
    logic signed [FRAC_W-1:0] a_num;
    logic [FRAC_W-1:0]        a_den;
    logic signed [FRAC_W-1:0] b_num;
    logic [FRAC_W-1:0]        b_den;
  } item_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] res_num;
    logic [DEN_W-1:0]        res_den;
    logic                    equal;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_GCD,
    ST_DIV,
    ST_OUT
  } ctrl_state_t;

  typedef enum logic [1:0] {
    GCD_IDLE,
    GCD_RUN,
    GCD_SCALE
  } gcd_state_t;

endpackage

// ===== src/ramr_mul.sv =====
// Bit-serial shift-and-add multiplier, three lanes sharing one bit counter.
module ramr_mul (
  input  logic                                                  clk,
  input  logic                                                  rst,
  input  logic                                                  start,
  input  logic [ramr_pkg::MUL_LANES-1:0][ramr_pkg::FRAC_W-1:0]  mcand,
  input  logic [ramr_pkg::MUL_LANES-1:0][ramr_pkg::FRAC_W-1:0]  mplier,
  output logic [ramr_pkg::MUL_LANES-1:0][ramr_pkg::MAG_W-1:0]   prod,
  output logic                                                  done
);

  logic [ramr_pkg::MUL_LANES-1:0][ramr_pkg::FRAC_W-1:0] mc;
  logic [ramr_pkg::MUL_LANES-1:0][ramr_pkg::MAG_W-1:0]  p;
  logic [ramr_pkg::MUL_LANES-1:0][ramr_pkg::MAG_W-1:0]  p_next;
  logic [ramr_pkg::MUL_LANES-1:0][ramr_pkg::FRAC_W:0]   psum;
  logic [ramr_pkg::MUL_CW-1:0]                          cnt;
  logic                                                 busy;

  // Upper half accumulates, whole register shifts right one bit per cycle while busy
  always_comb begin
    for (int i = 0; i < ramr_pkg::MUL_LANES; i++) begin
      psum[i]   = {1'b0, p[i][ramr_pkg::MAG_W-1:ramr_pkg::FRAC_W]}
                + (p[i][0] ? {1'b0, mc[i]} : '0);
      p_next[i] = {psum[i], p[i][ramr_pkg::FRAC_W-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= ramr_pkg::MUL_CW'(ramr_pkg::FRAC_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mc <= mcand;
      for (int i = 0; i < ramr_pkg::MUL_LANES; i++) begin
        p[i] <= {{ramr_pkg::FRAC_W{1'b0}}, mplier[i]};
      end
    end else if (busy) begin
      p <= p_next;
    end
  end

  assign prod = p;

endmodule

// ===== src/ramr_gcd.sv =====
// Binary (shift/subtract) GCD unit, one step per cycle, with serial rescale.
module ramr_gcd (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ramr_pkg::MAG_W-1:0] a,
  input  logic [ramr_pkg::MAG_W-1:0] b,
  output logic [ramr_pkg::MAG_W-1:0] g,
  output logic                       done
);

  ramr_pkg::gcd_state_t state, state_next;

  logic [ramr_pkg::MAG_W-1:0]  u;
  logic [ramr_pkg::MAG_W-1:0]  v;
  logic [ramr_pkg::GCD_KW-1:0] k;
  logic [ramr_pkg::MAG_W:0]    duv;
  logic [ramr_pkg::MAG_W:0]    dvu;
  logic                        done_set;

  assign duv = {1'b0, u} - {1'b0, v};
  assign dvu = {1'b0, v} - {1'b0, u};

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ramr_pkg::GCD_IDLE:  if (start) state_next = ramr_pkg::GCD_RUN;
      ramr_pkg::GCD_RUN:   if (u == '0 || v == '0) state_next = ramr_pkg::GCD_SCALE;
      ramr_pkg::GCD_SCALE: if (k == '0) state_next = ramr_pkg::GCD_IDLE;
      default:             state_next = ramr_pkg::GCD_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    done_set = (state == ramr_pkg::GCD_SCALE) && (k == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ramr_pkg::GCD_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_set;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ramr_pkg::GCD_IDLE: begin
        if (start) begin
          u <= a;
          v <= b;
          k <= '0;
        end
      end
      ramr_pkg::GCD_RUN: begin
        if (u == '0) begin
          u <= v;
        end else if (v != '0) begin
          case ({u[0], v[0]})
            2'b00: begin
              u <= u >> 1;
              v <= v >> 1;
              k <= k + 1'b1;
            end
            2'b01: u <= u >> 1;
            2'b10: v <= v >> 1;
            default: begin
              // both odd: difference is even, halve it
              if (!duv[ramr_pkg::MAG_W]) begin
                u <= duv[ramr_pkg::MAG_W:1];
              end else begin
                v <= dvu[ramr_pkg::MAG_W:1];
              end
            end
          endcase
        end
      end
      ramr_pkg::GCD_SCALE: begin
        // restore common factors of two
        if (k != '0) begin
          u <= u << 1;
          k <= k - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign g = u;

endmodule

// ===== src/ramr_div.sv =====
// Restoring bit-serial divider, two lanes sharing one divisor and counter.
module ramr_div (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic                                                start,
  input  logic [ramr_pkg::DIV_LANES-1:0][ramr_pkg::MAG_W-1:0] dividend,
  input  logic [ramr_pkg::MAG_W-1:0]                          divisor,
  output logic [ramr_pkg::DIV_LANES-1:0][ramr_pkg::MAG_W-1:0] quot,
  output logic                                                done
);

  logic [ramr_pkg::DIV_LANES-1:0][ramr_pkg::MAG_W-1:0] q;
  logic [ramr_pkg::DIV_LANES-1:0][ramr_pkg::MAG_W-1:0] r;
  logic [ramr_pkg::DIV_LANES-1:0][ramr_pkg::MAG_W-1:0] q_next;
  logic [ramr_pkg::DIV_LANES-1:0][ramr_pkg::MAG_W-1:0] r_next;
  logic [ramr_pkg::DIV_LANES-1:0][ramr_pkg::MAG_W:0]   sh;
  logic [ramr_pkg::DIV_LANES-1:0][ramr_pkg::MAG_W+1:0] trial;
  logic [ramr_pkg::MAG_W-1:0]                          d;
  logic [ramr_pkg::DIV_CW-1:0]                         cnt;
  logic                                                busy;

  always_comb begin
    for (int i = 0; i < ramr_pkg::DIV_LANES; i++) begin
      sh[i]     = {r[i], q[i][ramr_pkg::MAG_W-1]};
      trial[i]  = {1'b0, sh[i]} - {2'b00, d};
      r_next[i] = trial[i][ramr_pkg::MAG_W+1] ? sh[i][ramr_pkg::MAG_W-1:0]
                                              : trial[i][ramr_pkg::MAG_W-1:0];
      q_next[i] = {q[i][ramr_pkg::MAG_W-2:0], ~trial[i][ramr_pkg::MAG_W+1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= ramr_pkg::DIV_CW'(ramr_pkg::MAG_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      r <= '0;
      d <= divisor;
    end else if (busy) begin
      q <= q_next;
      r <= r_next;
    end
  end

  assign quot = q;

endmodule

// ===== src/rational_add_mul_reduce_top.sv =====
// Top level: rational add / multiply / compare with reduction to lowest terms.
// Add and multiply run the serial multiplier, the binary GCD loop with its rescale
//   and the serial divider in turn; a zero result skips the GCD and the divider.
//   Compare uses only the multiplier, and the unused action goes straight to output.
// One transaction is in flight at a time; the next is taken only back in idle.
// Reset (rst, synchronous, active high) empties the controller and output.
module rational_add_mul_reduce_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  ramr_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output ramr_pkg::result_t result
);

  ramr_pkg::ctrl_state_t state, state_next;

  // Input-side handshake: take a new transaction only when the datapath is idle.
  // The output register decouples the result side, so a finished result may
  // wait there while the next transaction is worked on.
  logic accept;
  logic act_valid;

  // Latched transaction attributes
  logic [1:0] act;
  logic       sa, sb;     // numerator signs
  logic       za, zb;     // numerators zero
  logic       ad0, bd0;   // denominators zero

  // Unreduced result and the finished result waiting for the output register
  logic [ramr_pkg::MAG_W-1:0] num_mag;
  logic                       num_neg;
  logic [ramr_pkg::MAG_W-1:0] den;
  ramr_pkg::result_t          fin;

  // Multiplier lanes
  logic [ramr_pkg::FRAC_W-1:0] mag_a, mag_b;
  logic [ramr_pkg::MUL_LANES-1:0][ramr_pkg::FRAC_W-1:0] mcand, mplier;
  logic [ramr_pkg::MUL_LANES-1:0][ramr_pkg::MAG_W-1:0]  prod;
  logic mul_start, mul_done;

  // GCD and divider
  logic [ramr_pkg::MAG_W-1:0] g;
  logic gcd_start, gcd_done;
  logic [ramr_pkg::DIV_LANES-1:0][ramr_pkg::MAG_W-1:0] quot;
  logic div_start, div_done;
  logic [ramr_pkg::NUM_W-1:0] qx;

  // Signed sum of the two cross products
  logic [ramr_pkg::MAG_W:0]   s_add, d01, d10;
  logic [ramr_pkg::MAG_W-1:0] add_mag;
  logic                       add_neg;
  logic                       eq;

  logic load_out;

  assign item_stall = (state != ramr_pkg::ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign act_valid  = (item.action == ramr_pkg::ACT_ADD) ||
                      (item.action == ramr_pkg::ACT_MUL) ||
                      (item.action == ramr_pkg::ACT_CMP);

  // Operand selection at accept; the multiplier latches its operands on start.
  // Lane 0: |a_num| * b_den (or |a_num| * |b_num| for multiply)
  // Lane 1: |b_num| * a_den
  // Lane 2: a_den * b_den
  always_comb begin
    mag_a = item.a_num[ramr_pkg::FRAC_W-1] ? ramr_pkg::FRAC_W'(-item.a_num)
                                           : ramr_pkg::FRAC_W'(item.a_num);
    mag_b = item.b_num[ramr_pkg::FRAC_W-1] ? ramr_pkg::FRAC_W'(-item.b_num)
                                           : ramr_pkg::FRAC_W'(item.b_num);
    mcand[0]  = mag_a;
    mplier[0] = (item.action == ramr_pkg::ACT_MUL) ? mag_b : item.b_den;
    mcand[1]  = mag_b;
    mplier[1] = item.a_den;
    mcand[2]  = item.a_den;
    mplier[2] = item.b_den;
  end

  assign mul_start = accept && act_valid;

  ramr_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .mcand  (mcand),
    .mplier (mplier),
    .prod   (prod),
    .done   (mul_done)
  );

  // Add: same signs add magnitudes, opposite signs take the larger minus smaller
  always_comb begin
    s_add = {1'b0, prod[0]} + {1'b0, prod[1]};
    d01   = {1'b0, prod[0]} - {1'b0, prod[1]};
    d10   = {1'b0, prod[1]} - {1'b0, prod[0]};
    if (sa == sb) begin
      add_mag = s_add[ramr_pkg::MAG_W-1:0];
      add_neg = sa;
    end else if (!d01[ramr_pkg::MAG_W]) begin
      add_mag = d01[ramr_pkg::MAG_W-1:0];
      add_neg = sa;
    end else begin
      add_mag = d10[ramr_pkg::MAG_W-1:0];
      add_neg = sb;
    end
  end

  // Compare: zero reduces to 0/1, a nonzero value over zero to +-1/0,
  // otherwise equal reduced forms means equal cross products.
  always_comb begin
    if (za && zb) begin
      eq = 1'b1;
    end else if (za || zb) begin
      eq = 1'b0;
    end else if (ad0 && bd0) begin
      eq = (sa == sb);
    end else if (ad0 || bd0) begin
      eq = 1'b0;
    end else begin
      eq = (sa == sb) && (prod[0] == prod[1]);
    end
  end

  ramr_gcd u_gcd (
    .clk   (clk),
    .rst   (rst),
    .start (gcd_start),
    .a     (num_mag),
    .b     (den),
    .g     (g),
    .done  (gcd_done)
  );

  ramr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({den, num_mag}),
    .divisor  (g),
    .quot     (quot),
    .done     (div_done)
  );

  assign qx = ramr_pkg::NUM_W'(quot[0]);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ramr_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = act_valid ? ramr_pkg::ST_MUL : ramr_pkg::ST_OUT;
        end
      end
      ramr_pkg::ST_MUL: begin
        if (mul_done) begin
          state_next = (act == ramr_pkg::ACT_CMP) ? ramr_pkg::ST_OUT : ramr_pkg::ST_PREP;
        end
      end
      ramr_pkg::ST_PREP: begin
        state_next = (num_mag == '0) ? ramr_pkg::ST_OUT : ramr_pkg::ST_GCD;
      end
      ramr_pkg::ST_GCD: if (gcd_done) state_next = ramr_pkg::ST_DIV;
      ramr_pkg::ST_DIV: if (div_done) state_next = ramr_pkg::ST_OUT;
      ramr_pkg::ST_OUT: begin
        if (!result_valid || !result_stall) state_next = ramr_pkg::ST_IDLE;
      end
      default: state_next = ramr_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    gcd_start = (state == ramr_pkg::ST_PREP) && (num_mag != '0);
    div_start = (state == ramr_pkg::ST_GCD) && gcd_done;
    load_out  = (state == ramr_pkg::ST_OUT) && (!result_valid || !result_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ramr_pkg::ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      act <= item.action;
      sa  <= item.a_num[ramr_pkg::FRAC_W-1];
      sb  <= item.b_num[ramr_pkg::FRAC_W-1];
      za  <= (item.a_num == '0);
      zb  <= (item.b_num == '0);
      ad0 <= (item.a_den == '0);
      bd0 <= (item.b_den == '0);
      fin <= '0;
    end

    if (state == ramr_pkg::ST_MUL && mul_done) begin
      den <= prod[2];
      case (act)
        ramr_pkg::ACT_ADD: begin
          num_mag <= add_mag;
          num_neg <= add_neg;
        end
        ramr_pkg::ACT_MUL: begin
          num_mag <= prod[0];
          num_neg <= sa ^ sb;
        end
        ramr_pkg::ACT_CMP: fin.equal <= eq;
        default: begin
        end
      endcase
    end

    // zero numerator always reduces to 0/1
    if (state == ramr_pkg::ST_PREP && num_mag == '0) begin
      fin.res_num <= '0;
      fin.res_den <= ramr_pkg::DEN_W'(1);
    end

    if (state == ramr_pkg::ST_DIV && div_done) begin
      fin.res_num <= num_neg ? -qx : qx;
      fin.res_den <= ramr_pkg::DEN_W'(quot[1]);
    end

    if (load_out) begin
      result <= fin;
    end
  end

endmodule
